[rtl/core/greedy_box_suppression_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the greedy box suppression unit
// Implication checks that are compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`define GREEDY_BOX_SUPPRESSION_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBS_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define GBS_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define GBS_ASSERT_NOW(lbl, a, c)
`define GBS_ASSERT_NEXT(lbl, a, c)
`endif
`endif

[rtl/core/gbs_pkg.sv]
// ---------------------------------------------------------------------------
// Greedy box suppression package
// Shared constants and the controller state type.
// ---------------------------------------------------------------------------
package gbs_pkg;
	localparam int MaxBoxesDef = 64;
	localparam logic [15:0] ThrReset = 16'd29491;
	localparam int BoxW = 96;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PASS,
		ST_FETCH,
		ST_LATCH,
		ST_AREA,
		ST_EMIT
	} state_t;
endpackage

[rtl/core/gbs_ram.sv]
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/greedy_box_suppression_unit.sv]
// ---------------------------------------------------------------------------
// Greedy box suppression unit
// Loads a set of boxes, then emits the survivors of greedy suppression.
// ---------------------------------------------------------------------------
// Boxes are taken one item per cycle until the final box of a set. Processing
// then runs passes over the box memory, one stored box per cycle through a
// five-stage overlap pipeline. The first pass finds the highest-scoring box;
// each later pass suppresses boxes overlapping the current survivor and finds
// the next one. Each survivor is fetched through the FETCH, LATCH and AREA
// states; the pass that then suppresses against it ends in EMIT, where the
// survivor is held until it is taken, and the unit is back in loading once
// the last survivor is taken. The single read port of the box memory sets the
// processing time.
`include "greedy_box_suppression_unit_assert.svh"
module greedy_box_suppression_unit import gbs_pkg::*; #(
	parameter int MAX_BOXES = MaxBoxesDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] left,
	input  logic signed [15:0] top,
	input  logic signed [15:0] right,
	input  logic signed [15:0] bottom,
	input  logic [15:0]        score,
	input  logic [15:0]        tag,
	input  logic               final_box,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] kept_left,
	output logic signed [15:0] kept_top,
	output logic signed [15:0] kept_right,
	output logic signed [15:0] kept_bottom,
	output logic [15:0]        kept_score,
	output logic [15:0]        kept_tag,
	output logic               end_of_list,
	output logic               overflowed
);
	localparam int IW = $clog2(MAX_BOXES);
	localparam int CW = $clog2(MAX_BOXES + 1);

	state_t state_q, state_d;
	logic [15:0] thr_q;
	logic [CW-1:0] cnt_q, iss_q;
	logic ovf_q, have_cur_q, found_q;
	logic [IW-1:0] best_q;
	logic [15:0] best_score_q;
	logic [MAX_BOXES-1:0] done_q;
	logic signed [15:0] cl_q, ct_q, cr_q, cb_q;
	logic [15:0] cs_q, ctag_q;
	logic signed [33:0] carea_q;

	logic ram_we;
	logic [IW-1:0] raddr;
	logic [BoxW-1:0] rdata;

	logic issuing, busy, pass_end;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [15:0] sc_s2, sc_s3, sc_s4, sc_s5;
	logic empty_s2, empty_s3, empty_s4, empty_s5;
	logic signed [16:0] iw_s2, ih_s2, bw_s2, bh_s2;
	logic signed [33:0] inter_s3, area_s3, inter_s4, inter_s5;
	logic signed [35:0] uni_s4;
	logic upos_s5;
	logic signed [52:0] prod_s5;

	logic signed [15:0] bl, bt, br, bb, il, it, ir, ib;
	logic ev, sup, cand;
	logic in_acc, out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign ram_we = in_acc && (cnt_q < CW'(MAX_BOXES));
	assign cfg_ready = 1'b1;

	gbs_ram #(.WIDTH(BoxW), .DEPTH(MAX_BOXES)) u_box_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[IW-1:0]),
		.wdata ({tag, score, bottom, right, top, left}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign issuing = (state_q == ST_PASS) && (iss_q < cnt_q);
	assign busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign pass_end = (state_q == ST_PASS) && !issuing && !busy;

	assign bl = rdata[15:0];
	assign bt = rdata[31:16];
	assign br = rdata[47:32];
	assign bb = rdata[63:48];
	assign il = (cl_q > bl) ? cl_q : bl;
	assign it = (ct_q > bt) ? ct_q : bt;
	assign ir = (cr_q < br) ? cr_q : br;
	assign ib = (cb_q < bb) ? cb_q : bb;

	assign ev = v_s5 && !done_q[idx_s5];
	assign sup = ev && have_cur_q && !empty_s5 && upos_s5 &&
		(53'(signed'({inter_s5, 16'h0000})) > prod_s5);
	assign cand = ev && !sup;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && final_box) begin
					state_d = ST_PASS;
				end
			end
			ST_PASS: begin
				if (pass_end) begin
					if (have_cur_q) begin
						state_d = ST_EMIT;
					end else if (found_q) begin
						state_d = ST_FETCH;
					end else begin
						state_d = ST_LOAD;
					end
				end
			end
			ST_FETCH: state_d = ST_LATCH;
			ST_LATCH: state_d = ST_AREA;
			ST_AREA: state_d = ST_PASS;
			ST_EMIT: begin
				if (out_acc) begin
					state_d = found_q ? ST_FETCH : ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_LOAD);
		out_valid = (state_q == ST_EMIT);
		raddr = (state_q == ST_FETCH) ? best_q : iss_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			thr_q <= ThrReset;
			cnt_q <= '0;
			iss_q <= '0;
			ovf_q <= 1'b0;
			have_cur_q <= 1'b0;
			found_q <= 1'b0;
			done_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (in_acc) begin
				if (ram_we) begin
					cnt_q <= cnt_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
				iss_q <= '0;
				found_q <= 1'b0;
			end
			if (issuing) begin
				iss_q <= iss_q + CW'(1);
			end
			v_s1 <= issuing;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (sup) begin
				done_q[idx_s5] <= 1'b1;
			end
			if (cand && (!found_q || sc_s5 > best_score_q)) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_FETCH) begin
				done_q[best_q] <= 1'b1;
			end
			if (state_q == ST_AREA) begin
				have_cur_q <= 1'b1;
				found_q <= 1'b0;
				iss_q <= '0;
			end
			if ((pass_end && !have_cur_q && !found_q) || (out_acc && !found_q)) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
				have_cur_q <= 1'b0;
				done_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IW-1:0];
		idx_s2 <= idx_s1;
		sc_s2 <= rdata[79:64];
		empty_s2 <= (ir < il) || (ib < it);
		iw_s2 <= 17'(ir) - 17'(il);
		ih_s2 <= 17'(ib) - 17'(it);
		bw_s2 <= 17'(br) - 17'(bl);
		bh_s2 <= 17'(bb) - 17'(bt);
		idx_s3 <= idx_s2;
		sc_s3 <= sc_s2;
		empty_s3 <= empty_s2;
		inter_s3 <= iw_s2 * ih_s2;
		area_s3 <= bw_s2 * bh_s2;
		idx_s4 <= idx_s3;
		sc_s4 <= sc_s3;
		empty_s4 <= empty_s3;
		inter_s4 <= inter_s3;
		uni_s4 <= 36'(carea_q) + 36'(area_s3) - 36'(inter_s3);
		idx_s5 <= idx_s4;
		sc_s5 <= sc_s4;
		empty_s5 <= empty_s4;
		inter_s5 <= inter_s4;
		upos_s5 <= (uni_s4 > 36'sd0);
		prod_s5 <= $signed({1'b0, thr_q}) * uni_s4;
		if (cand && (!found_q || sc_s5 > best_score_q)) begin
			best_q <= idx_s5;
			best_score_q <= sc_s5;
		end
		if (state_q == ST_LATCH) begin
			cl_q <= rdata[15:0];
			ct_q <= rdata[31:16];
			cr_q <= rdata[47:32];
			cb_q <= rdata[63:48];
			cs_q <= rdata[79:64];
			ctag_q <= rdata[95:80];
		end
		if (state_q == ST_AREA) begin
			carea_q <= (17'(cr_q) - 17'(cl_q)) * (17'(cb_q) - 17'(ct_q));
		end
	end

	assign kept_left = cl_q;
	assign kept_top = ct_q;
	assign kept_right = cr_q;
	assign kept_bottom = cb_q;
	assign kept_score = cs_q;
	assign kept_tag = ctag_q;
	assign end_of_list = !found_q;
	assign overflowed = ovf_q;

	`GBS_ASSERT_NOW(a_no_load_during_emit, out_valid, !in_ready)
	`GBS_ASSERT_NEXT(a_final_closes_set, in_acc && final_box, !in_ready)
	`GBS_ASSERT_NEXT(a_gap_between_items, out_acc && !end_of_list, !out_valid)
	`GBS_ASSERT_NOW(a_no_write_when_full, cnt_q == CW'(MAX_BOXES), !ram_we)
endmodule
